FILE: hdl/nfa_epsilon_word_matcher_defines.svh
// ----------------------------------------------------------------------------
// nfa_epsilon_word_matcher_defines.svh
// Assertion macros used by the checker file of the word matcher.
// ----------------------------------------------------------------------------
`ifndef NFA_EPSILON_WORD_MATCHER_DEFINES_SVH
`define NFA_EPSILON_WORD_MATCHER_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define NFA_EWM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nfa_epsilon_word_matcher: same-cycle check failed");

// Next-cycle implication, quiet while reset is high.
`define NFA_EWM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nfa_epsilon_word_matcher: next-cycle check failed");

// Next-cycle implication that also watches the reset cycles themselves.
`define NFA_EWM_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("nfa_epsilon_word_matcher: reset check failed");

`endif

FILE: hdl/nfa_ewm_pkg.sv
// ----------------------------------------------------------------------------
// nfa_ewm_pkg
// Constants, types and helpers of the epsilon-NFA word matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nfa_ewm_pkg;

   localparam int NUM_STATES    = 16;
   localparam int SYMBOL_BITS   = 8;
   localparam int STATE_BITS    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int ADDR_BITS     = SYMBOL_BITS + STATE_BITS;
   localparam int TABLE_DEPTH   = 1 << ADDR_BITS;
   localparam int EPSILON_LABEL = 64;

   // fixed field widths of the channels
   localparam int OPCODE_W   = 2;
   localparam int STATE_W    = 4;
   localparam int SYMBOL_W   = 8;
   localparam int SET_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [NUM_STATES-1:0]  state_set_type;
   typedef logic [STATE_BITS-1:0]  state_idx_type;
   typedef logic [SYMBOL_BITS-1:0] sym_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [OPCODE_W-1:0]    opcode_type;

   localparam opcode_type OP_ADD_TRANS  = 2'd0;
   localparam opcode_type OP_START_WORD = 2'd1;
   localparam opcode_type OP_SYMBOL     = 2'd2;
   localparam opcode_type OP_END_WORD   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HAS_START   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_MASK  = 2'd2;

   localparam sym_type EPS_SYM = SYMBOL_BITS'(EPSILON_LABEL);

   // controller to datapath
   typedef struct packed {
      logic clear_wr;    // write zero at the sweep counter, advance it
      logic capture;     // latch the incoming beat
      logic init_zero;   // accumulator <= 0, restart the scan
      logic init_start;  // accumulator <= start set, restart the scan
      logic scan_en;     // issue one table read per pending state
      logic scan_grow;   // closure mode: scan the growing accumulator
      logic rescan;      // clear the visited set
      logic commit;      // active set <= accumulator
      logic add_rd;      // read the entry of the captured transition
      logic add_wr;      // write the entry back with the new bit
      logic emit;        // load the result register
   } nfa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic scan_idle;
      logic rsp_free;
   } nfa_status_type;

   function automatic logic state_in_range(input logic [STATE_W-1:0] f);
      return (int'(f) < NUM_STATES);
   endfunction

   function automatic state_idx_type state_idx(input logic [STATE_W-1:0] f);
      return STATE_BITS'(f);
   endfunction

   function automatic state_set_type state_bit(input state_idx_type i);
      return state_set_type'(1) << i;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/nfa_ewm_if.sv
// ----------------------------------------------------------------------------
// nfa_ewm_if
// Valid/ready channel interfaces of the word matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nfa_ewm_req_if;
   logic                                req_valid;
   logic                                req_ready;
   logic [nfa_ewm_pkg::OPCODE_W-1:0]    req_opcode;
   logic [nfa_ewm_pkg::STATE_W-1:0]     req_source_state;
   logic [nfa_ewm_pkg::SYMBOL_W-1:0]    req_symbol;
   logic [nfa_ewm_pkg::STATE_W-1:0]     req_dest_state;

   modport source (output req_valid, req_opcode, req_source_state, req_symbol,
                   req_dest_state, input req_ready);
   modport sink   (input req_valid, req_opcode, req_source_state, req_symbol,
                   req_dest_state, output req_ready);
endinterface

interface nfa_ewm_rsp_if;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_accepted;
   logic [nfa_ewm_pkg::SET_W-1:0]    rsp_final_set;

   modport source (output rsp_valid, rsp_accepted, rsp_final_set, input rsp_ready);
   modport sink   (input rsp_valid, rsp_accepted, rsp_final_set, output rsp_ready);
endinterface

interface nfa_ewm_csr_if;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [nfa_ewm_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [nfa_ewm_pkg::CSR_DATA_W-1:0]   csr_data;

   modport source (output csr_valid, csr_index, csr_data, input csr_ready);
   modport sink   (input csr_valid, csr_index, csr_data, output csr_ready);
endinterface

`default_nettype wire

FILE: hdl/nfa_ewm_ram.sv
// ----------------------------------------------------------------------------
// nfa_ewm_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfa_ewm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/nfa_ewm_dpath.sv
// ----------------------------------------------------------------------------
// nfa_ewm_dpath
// Transition table, state-set scanner, configuration and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfa_ewm_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  nfa_ewm_pkg::nfa_cmd_type            cmd,
   output nfa_ewm_pkg::nfa_status_type         status,
   input  logic [nfa_ewm_pkg::STATE_W-1:0]     in_source_state,
   input  logic [nfa_ewm_pkg::SYMBOL_W-1:0]    in_symbol,
   input  logic [nfa_ewm_pkg::STATE_W-1:0]     in_dest_state,
   input  logic                                csr_we,
   input  logic [nfa_ewm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nfa_ewm_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_accepted,
   output logic [nfa_ewm_pkg::SET_W-1:0]       rsp_final_set
);

   // captured item
   logic [nfa_ewm_pkg::STATE_W-1:0] src_ff, dst_ff;
   nfa_ewm_pkg::sym_type            sym_ff;

   // configuration
   logic                            has_start_ff;
   logic [nfa_ewm_pkg::STATE_W-1:0] start_ff;
   logic [nfa_ewm_pkg::SET_W-1:0]   mask_ff;

   // set registers
   nfa_ewm_pkg::state_set_type active_ff, active_in;
   nfa_ewm_pkg::state_set_type acc_ff, acc_in;
   nfa_ewm_pkg::state_set_type done_ff, done_in;
   logic                       pend_ff, pend_in;

   nfa_ewm_pkg::addr_type      clr_cnt_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_acc_ff;
   logic [nfa_ewm_pkg::SET_W-1:0] rsp_set_ff;

   // table port
   logic                          ram_we;
   nfa_ewm_pkg::addr_type         ram_waddr, ram_raddr;
   nfa_ewm_pkg::state_set_type    ram_wdata, ram_rdata;

   nfa_ewm_pkg::state_set_type cur_acc, scan_view, cand, pick, start_set;
   nfa_ewm_pkg::state_idx_type pick_idx;
   nfa_ewm_pkg::sym_type       scan_sym;
   nfa_ewm_pkg::addr_type      add_addr;
   logic                       add_ok;

   nfa_ewm_ram #(
      .WIDTH (nfa_ewm_pkg::NUM_STATES),
      .DEPTH (nfa_ewm_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // scan: fold in the row that came back, pick the lowest unvisited state
   always_comb begin
      cur_acc   = acc_ff | (pend_ff ? ram_rdata : '0);
      scan_view = cmd.scan_grow ? cur_acc : active_ff;
      cand      = scan_view & ~done_ff;
      pick      = cand & (~cand + nfa_ewm_pkg::state_set_type'(1));
      pick_idx  = '0;
      for (int i = 0; i < nfa_ewm_pkg::NUM_STATES; i++) begin
         if (pick[i]) begin
            pick_idx = pick_idx | nfa_ewm_pkg::STATE_BITS'(i);
         end
      end
   end

   assign scan_sym = cmd.scan_grow ? nfa_ewm_pkg::EPS_SYM : sym_ff;
   assign add_addr = {sym_ff, nfa_ewm_pkg::state_idx(src_ff)};
   assign add_ok   = nfa_ewm_pkg::state_in_range(src_ff)
                     && nfa_ewm_pkg::state_in_range(dst_ff);

   assign start_set = (has_start_ff && nfa_ewm_pkg::state_in_range(start_ff))
                      ? nfa_ewm_pkg::state_bit(nfa_ewm_pkg::state_idx(start_ff)) : '0;

   always_comb begin
      ram_raddr = cmd.add_rd ? add_addr : {scan_sym, pick_idx};
      ram_we    = cmd.clear_wr || (cmd.add_wr && add_ok);
      ram_waddr = cmd.clear_wr ? clr_cnt_ff : add_addr;
      ram_wdata = cmd.clear_wr ? '0
                  : (ram_rdata | nfa_ewm_pkg::state_bit(nfa_ewm_pkg::state_idx(dst_ff)));
   end

   always_comb begin
      acc_in    = acc_ff;
      done_in   = done_ff;
      pend_in   = 1'b0;
      active_in = active_ff;
      if (cmd.init_zero) begin
         acc_in  = '0;
         done_in = '0;
      end else if (cmd.init_start) begin
         acc_in  = start_set;
         done_in = '0;
      end else if (cmd.scan_en) begin
         acc_in = cur_acc;
         if (cand != '0) begin
            done_in = done_ff | pick;
            pend_in = 1'b1;
         end
         if (cmd.rescan) begin
            done_in = '0;
         end
      end
      if (cmd.commit) begin
         active_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         pend_ff      <= 1'b0;
         clr_cnt_ff   <= '0;
         has_start_ff <= 1'b0;
         start_ff     <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + nfa_ewm_pkg::addr_type'(1);
         end
         if (csr_we) begin
            unique case (csr_index)
               nfa_ewm_pkg::CSR_HAS_START:   has_start_ff <= csr_data[0];
               nfa_ewm_pkg::CSR_START_STATE: start_ff <= csr_data[nfa_ewm_pkg::STATE_W-1:0];
               nfa_ewm_pkg::CSR_FINAL_MASK:  mask_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      done_ff <= done_in;
      if (cmd.capture) begin
         src_ff <= in_source_state;
         sym_ff <= in_symbol[nfa_ewm_pkg::SYMBOL_BITS-1:0];
         dst_ff <= in_dest_state;
      end
      if (cmd.emit) begin
         rsp_acc_ff <= |(active_ff & nfa_ewm_pkg::NUM_STATES'(mask_ff));
         rsp_set_ff <= nfa_ewm_pkg::SET_W'(active_ff);
      end
   end

   assign status.clear_last = &clr_cnt_ff;
   assign status.scan_idle  = (cand == '0) && !pend_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_acc_ff;
   assign rsp_final_set = rsp_set_ff;

endmodule

`default_nettype wire

FILE: hdl/nfa_ewm_ctrl.sv
// ----------------------------------------------------------------------------
// nfa_ewm_ctrl
// Sequencer: table sweep, transition insert, successor scan, closure, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfa_ewm_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [nfa_ewm_pkg::OPCODE_W-1:0] req_opcode,
   output logic                             req_ready,
   input  nfa_ewm_pkg::nfa_status_type      status,
   output nfa_ewm_pkg::nfa_cmd_type         cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ADD_RD = 3'd2;
   localparam logic [2:0] ST_ADD_WR = 3'd3;
   localparam logic [2:0] ST_SUCC   = 3'd4;
   localparam logic [2:0] ST_CLOS   = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_opcode)
                  nfa_ewm_pkg::OP_ADD_TRANS: state_in = ST_ADD_RD;
                  nfa_ewm_pkg::OP_START_WORD: begin
                     cmd.init_start = 1'b1;
                     state_in       = ST_CLOS;
                  end
                  nfa_ewm_pkg::OP_SYMBOL: begin
                     cmd.init_zero = 1'b1;
                     state_in      = ST_SUCC;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_ADD_RD: begin
            cmd.add_rd = 1'b1;
            state_in   = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SUCC: begin
            cmd.scan_en = 1'b1;
            if (status.scan_idle) begin
               cmd.rescan = 1'b1;
               state_in   = ST_CLOS;
            end
         end
         ST_CLOS: begin
            cmd.scan_en   = 1'b1;
            cmd.scan_grow = 1'b1;
            if (status.scan_idle) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/nfa_epsilon_word_matcher.sv
// ----------------------------------------------------------------------------
// nfa_epsilon_word_matcher
// Bit-set NFA word matcher with epsilon closure over a stored transition table.
// ----------------------------------------------------------------------------
//
//   channel | dir | fields                                      | beat moves on
//   --------+-----+---------------------------------------------+-------------------
//   req     | in  | opcode, source_state, symbol, dest_state    | req_valid & req_ready
//   rsp     | out | accepted, final_set                         | rsp_valid & rsp_ready
//   csr     | in  | csr_index, csr_data                         | csr_valid & csr_ready
//
//   Steps: add transition reads the table entry and writes it back with the new
//   bit; start word loads the start set and runs the closure; symbol scans the
//   active states, then the closure; end word loads the result register (it
//   waits while that register stays full). The single table read port visits
//   one state per cycle; each pass drains its last read and sees that it settled.
//   Reset: synchronous; afterwards the table is swept to zero, one entry per
//   cycle, over all TABLE_DEPTH (4096) entries, req_ready low. csr is always ready.
//   Stalls: a full result register holds an end-word beat in the sequencer;
//   other beats still pass until then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfa_epsilon_word_matcher (
   input  logic          clock,
   input  logic          reset,
   nfa_ewm_req_if.sink   req,
   nfa_ewm_rsp_if.source rsp,
   nfa_ewm_csr_if.sink   csr
);

   nfa_ewm_pkg::nfa_cmd_type    cmd;
   nfa_ewm_pkg::nfa_status_type status;
   logic                        req_ready;

   // configuration writes go straight into their registers, so never back-pressure them
   assign csr.csr_ready = 1'b1;
   assign req.req_ready = req_ready;

   // sequencer: owns the only state machine, drives the datapath by commands
   nfa_ewm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.req_valid),
      .req_opcode (req.req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: table RAM, set scanner, config and the result register
   nfa_ewm_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_source_state (req.req_source_state),
      .in_symbol       (req.req_symbol),
      .in_dest_state   (req.req_dest_state),
      .csr_we          (csr.csr_valid),
      .csr_index       (csr.csr_index),
      .csr_data        (csr.csr_data),
      .rsp_ready       (rsp.rsp_ready),
      .rsp_valid       (rsp.rsp_valid),
      .rsp_accepted    (rsp.rsp_accepted),
      .rsp_final_set   (rsp.rsp_final_set)
   );

endmodule

`default_nettype wire

FILE: hdl/nfa_ewm_checker.sv
// ----------------------------------------------------------------------------
// nfa_ewm_checker
// Port-level checks of the word matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "nfa_epsilon_word_matcher_defines.svh"

module nfa_ewm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_accepted,
   input logic [nfa_ewm_pkg::SET_W-1:0] rsp_final_set
);

   // hold a result until it is taken
   `NFA_EWM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // hold the payload of a stalled result
   `NFA_EWM_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
                        $stable(rsp_final_set) && $stable(rsp_accepted))
   // an empty final set can never be accepting
   `NFA_EWM_ASSERT_SAME(a_empty_reject, rsp_valid && (rsp_final_set == '0), !rsp_accepted)
   // the table sweep follows reset, so no beat is taken right after it
   `NFA_EWM_ASSERT_NEXT_ALWAYS(a_sweep_after_reset, reset, !req_ready)

endmodule

bind nfa_epsilon_word_matcher nfa_ewm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.req_ready),
   .rsp_valid     (rsp.rsp_valid),
   .rsp_ready     (rsp.rsp_ready),
   .rsp_accepted  (rsp.rsp_accepted),
   .rsp_final_set (rsp.rsp_final_set)
);

`default_nettype wire
